// ===== rtl/bmwa_pkg.sv =====
// Shared types, constants and address decode for the banked memory word access block.
// Used by banked_memory_word_access, bmwa_access_checker and the bench; depends on nothing else.
package bmwa_pkg;

   localparam int NUM_BANKS  = 4;
   localparam int HALF_SIZE  = 32768;
   localparam int ADDR_W     = 16;
   localparam int DATA_W     = 16;
   localparam int BYTE_W     = 8;

   localparam logic [ADDR_W-1:0] TOP_ADDR = 16'hFFFF;

   // Each store is split into an even-byte and an odd-byte array
   localparam int LOW_AW       = $clog2(HALF_SIZE);
   localparam int LOW_DEPTH    = HALF_SIZE / 2;
   localparam int LOW_IDX_W    = $clog2(LOW_DEPTH);
   localparam int BANK_DEPTH   = NUM_BANKS * HALF_SIZE / 2;
   localparam int BANK_IDX_W   = $clog2(BANK_DEPTH);
   localparam int NUM_MEMS     = 4;

   localparam int CSR_IDX_W    = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_LOW    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_HIGH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REMAP_ENABLE = 2'd2;

   localparam logic [1:0] REQ_BYTE_READ  = 2'd0;
   localparam logic [1:0] REQ_BYTE_WRITE = 2'd1;
   localparam logic [1:0] REQ_WORD_READ  = 2'd2;
   localparam logic [1:0] REQ_WORD_WRITE = 2'd3;

   localparam logic [1:0] FAULT_NONE  = 2'd0;
   localparam logic [1:0] FAULT_TOP   = 2'd1;
   localparam logic [1:0] FAULT_RANGE = 2'd2;

   localparam logic [1:0] MEM_LOW_EVEN  = 2'd0;
   localparam logic [1:0] MEM_LOW_ODD   = 2'd1;
   localparam logic [1:0] MEM_BANK_EVEN = 2'd2;
   localparam logic [1:0] MEM_BANK_ODD  = 2'd3;

   typedef struct packed {
      logic [1:0]            mem_id;
      logic [BANK_IDX_W-1:0] index;
   } loc_type;

   // Map a byte address to its array and entry
   function automatic loc_type locate(input logic [ADDR_W-1:0] addr,
                                      input logic [ADDR_W-1:0] bank_select);
      logic [ADDR_W-1:0]     off;
      logic [BANK_IDX_W-1:0] bank;
      loc_type               loc;
      bank = BANK_IDX_W'(bank_select % ADDR_W'(NUM_BANKS));
      off  = addr - ADDR_W'(HALF_SIZE);
      if (addr < ADDR_W'(HALF_SIZE)) begin
         loc.mem_id = addr[0] ? MEM_LOW_ODD : MEM_LOW_EVEN;
         loc.index  = BANK_IDX_W'(addr[LOW_AW-1:1]);
      end else begin
         loc.mem_id = addr[0] ? MEM_BANK_ODD : MEM_BANK_EVEN;
         loc.index  = BANK_IDX_W'(bank * BANK_IDX_W'(LOW_DEPTH))
                      + BANK_IDX_W'(off[LOW_AW-1:1]);
      end
      return loc;
   endfunction

endpackage

// ===== rtl/bmwa_byte_ram.sv =====
// Single-port byte RAM with registered read data.
// Generic; no package dependency.
module bmwa_byte_ram #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              en,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [7:0]        wdata,
   output logic [7:0]        rdata
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/banked_memory_word_access.sv =====
// Banked byte RAM with little-endian word access: one request per clock, busy is always
// low, and each request gets exactly one response on rsp_valid, passing through the
// request register, RAM access and response register. Both bytes of a word are served
// in the same cycle since every store is split into even- and odd-byte arrays; the
// receiver cannot stall. The range registers may only be changed while no request is open.
// Depends on bmwa_pkg and bmwa_byte_ram.
module banked_memory_word_access (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_type,
   input  logic [bmwa_pkg::ADDR_W-1:0]     req_address,
   input  logic [bmwa_pkg::DATA_W-1:0]     req_write_data,
   input  logic [bmwa_pkg::ADDR_W-1:0]     req_bank_select,
   output logic                            rsp_valid,
   output logic [bmwa_pkg::DATA_W-1:0]     rsp_read_data,
   output logic [1:0]                      rsp_fault,
   input  logic                            csr_write_enable,
   input  logic [bmwa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bmwa_pkg::DATA_W-1:0]     csr_write_data
);

   logic [bmwa_pkg::ADDR_W-1:0] range_low_ff;
   logic [bmwa_pkg::ADDR_W-1:0] range_high_ff;
   logic                        remap_ff;

   logic                        s1_valid_ff;
   logic [1:0]                  s1_type_ff;
   logic [bmwa_pkg::ADDR_W-1:0] s1_addr_ff;
   logic [bmwa_pkg::DATA_W-1:0] s1_wdata_ff;
   logic [bmwa_pkg::ADDR_W-1:0] s1_bank_ff;

   logic [bmwa_pkg::ADDR_W-1:0] span_first;
   logic [bmwa_pkg::ADDR_W-1:0] span_last;
   logic [bmwa_pkg::ADDR_W-1:0] addr_next;
   bmwa_pkg::loc_type           loc0;
   bmwa_pkg::loc_type           loc1;
   logic                        is_word;
   logic                        is_write;
   logic [1:0]                  fault;
   logic                        second;

   logic                            mem_en    [bmwa_pkg::NUM_MEMS];
   logic [bmwa_pkg::BANK_IDX_W-1:0] mem_addr  [bmwa_pkg::NUM_MEMS];
   logic [7:0]                      mem_wdata [bmwa_pkg::NUM_MEMS];
   logic [7:0]                      mem_rdata [bmwa_pkg::NUM_MEMS];

   logic                        s2_valid_ff;
   logic                        s2_read_ff;
   logic                        s2_second_ff;
   logic [1:0]                  s2_fault_ff;
   logic [1:0]                  s2_id0_ff;
   logic [1:0]                  s2_id1_ff;

   logic                        rsp_valid_ff;
   logic [bmwa_pkg::DATA_W-1:0] rsp_read_data_ff;
   logic [bmwa_pkg::DATA_W-1:0] rsp_read_data_in;
   logic [1:0]                  rsp_fault_ff;

   // Configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= '0;
         range_high_ff <= bmwa_pkg::TOP_ADDR;
         remap_ff      <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            bmwa_pkg::CSR_RANGE_LOW:    range_low_ff  <= csr_write_data;
            bmwa_pkg::CSR_RANGE_HIGH:   range_high_ff <= csr_write_data;
            bmwa_pkg::CSR_REMAP_ENABLE: remap_ff      <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         s1_type_ff  <= req_type;
         s1_addr_ff  <= req_address;
         s1_wdata_ff <= req_write_data;
         s1_bank_ff  <= req_bank_select;
      end
   end

   // Decode and range check
   always_comb begin
      span_first  = remap_ff ? '0 : range_low_ff;
      span_last   = remap_ff ? range_high_ff - range_low_ff : range_high_ff;
      addr_next   = s1_addr_ff + bmwa_pkg::ADDR_W'(1);
      loc0        = bmwa_pkg::locate(s1_addr_ff, s1_bank_ff);
      loc1        = bmwa_pkg::locate(addr_next, s1_bank_ff);
      is_word     = (s1_type_ff == bmwa_pkg::REQ_WORD_READ) ||
                    (s1_type_ff == bmwa_pkg::REQ_WORD_WRITE);
      is_write    = (s1_type_ff == bmwa_pkg::REQ_BYTE_WRITE) ||
                    (s1_type_ff == bmwa_pkg::REQ_WORD_WRITE);
      if (!is_word) begin
         fault = bmwa_pkg::FAULT_NONE;
      end else if (s1_addr_ff == bmwa_pkg::TOP_ADDR) begin
         fault = bmwa_pkg::FAULT_TOP;
      end else if (addr_next >= span_first && addr_next <= span_last) begin
         fault = bmwa_pkg::FAULT_NONE;
      end else begin
         fault = bmwa_pkg::FAULT_RANGE;
      end
      second = is_word && (fault == bmwa_pkg::FAULT_NONE);
   end

   // The two bytes of a word have opposite parity, so they never share an array
   always_comb begin
      for (int m = 0; m < bmwa_pkg::NUM_MEMS; m++) begin
         mem_en[m]    = s1_valid_ff && ((loc0.mem_id == 2'(m)) ||
                        (second && (loc1.mem_id == 2'(m))));
         mem_addr[m]  = (loc0.mem_id == 2'(m)) ? loc0.index : loc1.index;
         mem_wdata[m] = (loc0.mem_id == 2'(m)) ? s1_wdata_ff[7:0] : s1_wdata_ff[15:8];
      end
   end

   bmwa_byte_ram #(.DEPTH(bmwa_pkg::LOW_DEPTH)) u_low_even (
      .clock (clock),
      .en    (mem_en[bmwa_pkg::MEM_LOW_EVEN]),
      .we    (is_write),
      .addr  (mem_addr[bmwa_pkg::MEM_LOW_EVEN][bmwa_pkg::LOW_IDX_W-1:0]),
      .wdata (mem_wdata[bmwa_pkg::MEM_LOW_EVEN]),
      .rdata (mem_rdata[bmwa_pkg::MEM_LOW_EVEN])
   );

   bmwa_byte_ram #(.DEPTH(bmwa_pkg::LOW_DEPTH)) u_low_odd (
      .clock (clock),
      .en    (mem_en[bmwa_pkg::MEM_LOW_ODD]),
      .we    (is_write),
      .addr  (mem_addr[bmwa_pkg::MEM_LOW_ODD][bmwa_pkg::LOW_IDX_W-1:0]),
      .wdata (mem_wdata[bmwa_pkg::MEM_LOW_ODD]),
      .rdata (mem_rdata[bmwa_pkg::MEM_LOW_ODD])
   );

   bmwa_byte_ram #(.DEPTH(bmwa_pkg::BANK_DEPTH)) u_bank_even (
      .clock (clock),
      .en    (mem_en[bmwa_pkg::MEM_BANK_EVEN]),
      .we    (is_write),
      .addr  (mem_addr[bmwa_pkg::MEM_BANK_EVEN]),
      .wdata (mem_wdata[bmwa_pkg::MEM_BANK_EVEN]),
      .rdata (mem_rdata[bmwa_pkg::MEM_BANK_EVEN])
   );

   bmwa_byte_ram #(.DEPTH(bmwa_pkg::BANK_DEPTH)) u_bank_odd (
      .clock (clock),
      .en    (mem_en[bmwa_pkg::MEM_BANK_ODD]),
      .we    (is_write),
      .addr  (mem_addr[bmwa_pkg::MEM_BANK_ODD]),
      .wdata (mem_wdata[bmwa_pkg::MEM_BANK_ODD]),
      .rdata (mem_rdata[bmwa_pkg::MEM_BANK_ODD])
   );

   // RAM access stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_read_ff   <= !is_write;
      s2_second_ff <= second;
      s2_fault_ff  <= fault;
      s2_id0_ff    <= loc0.mem_id;
      s2_id1_ff    <= loc1.mem_id;
   end

   // Response register; writes return zero data
   always_comb begin
      if (!s2_read_ff) begin
         rsp_read_data_in = '0;
      end else if (s2_second_ff) begin
         rsp_read_data_in = {mem_rdata[s2_id1_ff], mem_rdata[s2_id0_ff]};
      end else begin
         rsp_read_data_in = {8'd0, mem_rdata[s2_id0_ff]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_read_data_ff <= rsp_read_data_in;
      rsp_fault_ff     <= s2_fault_ff;
   end

   assign busy          = 1'b0;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_fault     = rsp_fault_ff;

`ifndef SYNTHESIS
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      start |-> ##3 rsp_valid)
      else $error("request accepted but no response three cycles later");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      !start |-> ##3 !rsp_valid)
      else $error("response without a request");

   a_top_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_fault == bmwa_pkg::FAULT_TOP)
      |-> ($past(req_address, 3) == bmwa_pkg::TOP_ADDR))
      else $error("top-address fault for a request not at the top address");

   a_split_bytes: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && second |-> (loc0.mem_id != loc1.mem_id))
      else $error("both bytes of a word mapped to one array");
`endif

endmodule

// ===== bench/bmwa_access_checker.sv =====
// Checker for banked_memory_word_access: watches the request, response and CSR ports,
// predicts each response from its own byte image of the stores, and counts mismatches.
// Depends on bmwa_pkg.
module bmwa_access_checker
   import bmwa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic [1:0]           req_type,
   input  logic [ADDR_W-1:0]    req_address,
   input  logic [DATA_W-1:0]    req_write_data,
   input  logic [ADDR_W-1:0]    req_bank_select,
   input  logic                 rsp_valid,
   input  logic [DATA_W-1:0]    rsp_read_data,
   input  logic [1:0]           rsp_fault,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_write_data,
   output int                   failures,
   output int                   outstanding
);

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [1:0]        fault;
   } access_result_type;

   // low store first, then the banks one after another
   localparam int IMAGE_SIZE = HALF_SIZE + NUM_BANKS * HALF_SIZE;

   logic [BYTE_W-1:0] mem_image [IMAGE_SIZE];
   logic [ADDR_W-1:0] win_low;
   logic [ADDR_W-1:0] win_high;
   logic              remap_on;
   access_result_type expected_results [$];

   function automatic int image_slot(input logic [ADDR_W-1:0] addr,
                                     input logic [ADDR_W-1:0] bank_sel);
      if (int'(addr) < HALF_SIZE) return int'(addr);
      return HALF_SIZE + int'(bank_sel % ADDR_W'(NUM_BANKS)) * HALF_SIZE
             + (int'(addr) - HALF_SIZE) % HALF_SIZE;
   endfunction

   function automatic logic [1:0] word_fault(input logic [ADDR_W-1:0] addr);
      logic [ADDR_W-1:0] first;
      logic [ADDR_W-1:0] last;
      int                next_byte;
      first = remap_on ? '0 : win_low;
      last  = remap_on ? ADDR_W'(win_high - win_low) : win_high;
      if (addr == TOP_ADDR) return FAULT_TOP;
      next_byte = int'(addr) + 1;
      if (next_byte >= int'(first) && next_byte <= int'(last)) return FAULT_NONE;
      return FAULT_RANGE;
   endfunction

   // Applies one request to the image and returns the response it should produce
   function automatic access_result_type apply_access(input logic [1:0]        kind,
                                                      input logic [ADDR_W-1:0] addr,
                                                      input logic [DATA_W-1:0] data,
                                                      input logic [ADDR_W-1:0] bank_sel);
      access_result_type res;
      int                lo_slot;
      int                hi_slot;
      res     = '0;
      lo_slot = image_slot(addr, bank_sel);
      hi_slot = image_slot(ADDR_W'(addr + ADDR_W'(1)), bank_sel);
      case (kind)
         REQ_BYTE_READ: begin
            res.read_data = {8'h00, mem_image[lo_slot]};
         end
         REQ_BYTE_WRITE: begin
            mem_image[lo_slot] = data[7:0];
         end
         REQ_WORD_READ: begin
            res.fault     = word_fault(addr);
            res.read_data = {8'h00, mem_image[lo_slot]};
            if (res.fault == FAULT_NONE) res.read_data[15:8] = mem_image[hi_slot];
         end
         REQ_WORD_WRITE: begin
            mem_image[lo_slot] = data[7:0];
            res.fault          = word_fault(addr);
            if (res.fault == FAULT_NONE) mem_image[hi_slot] = data[15:8];
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      access_result_type want;
      if (reset) begin
         win_low  = '0;
         win_high = TOP_ADDR;
         remap_on = 1'b0;
         failures = 0;
         expected_results.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_RANGE_LOW:    win_low  = csr_write_data;
               CSR_RANGE_HIGH:   win_high = csr_write_data;
               CSR_REMAP_ENABLE: remap_on = csr_write_data[0];
               default: ;
            endcase
         end
         // push before pop so a same-edge response would still find its request
         if (start && !busy) begin
            expected_results.push_back(apply_access(req_type, req_address,
                                                    req_write_data, req_bank_select));
         end
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               failures++;
               $display("%0t: response with no request open, expected none, actual %h/%0d",
                        $time, rsp_read_data, rsp_fault);
            end else begin
               want = expected_results.pop_front();
               if (rsp_read_data !== want.read_data) begin
                  failures++;
                  $display("%0t: read_data mismatch, expected %h, actual %h",
                           $time, want.read_data, rsp_read_data);
               end
               if (rsp_fault !== want.fault) begin
                  failures++;
                  $display("%0t: fault mismatch, expected %0d, actual %0d",
                           $time, want.fault, rsp_fault);
               end
            end
         end
      end
      outstanding = expected_results.size();
   end

endmodule

// ===== bench/banked_memory_word_access_tb.sv =====
// Top of the banked_memory_word_access bench: clock, reset, CSR phases and request stimulus.
// Checking is done by bmwa_access_checker; depends on bmwa_pkg and the block itself.
module banked_memory_word_access_tb;
   import bmwa_pkg::*;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int RANDOM_PER_PHASE = 195;
   localparam int NUM_PHASES       = 9;
   localparam int SETTLE_CYCLES    = 6;
   localparam int IMAGE_SIZE       = HALF_SIZE + NUM_BANKS * HALF_SIZE;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 start            = 1'b0;
   logic                 busy;
   logic [1:0]           req_type         = REQ_BYTE_READ;
   logic [ADDR_W-1:0]    req_address      = '0;
   logic [DATA_W-1:0]    req_write_data   = '0;
   logic [ADDR_W-1:0]    req_bank_select  = '0;
   logic                 rsp_valid;
   logic [DATA_W-1:0]    rsp_read_data;
   logic [1:0]           rsp_fault;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = CSR_RANGE_LOW;
   logic [DATA_W-1:0]    csr_write_data   = '0;

   int                   failures;
   int                   outstanding;
   int                   cycles           = 0;
   bit                   idle_enable      = 1'b1;
   bit                   byte_written [IMAGE_SIZE];
   logic [ADDR_W-1:0]    cur_low          = '0;
   logic [ADDR_W-1:0]    cur_high         = TOP_ADDR;

   // phase 0 runs with the reset values
   logic [ADDR_W-1:0] phase_low   [NUM_PHASES] = '{16'h0000, 16'h1000, 16'h9000, 16'h9000,
                                                   16'h4000, 16'h0000, 16'hFFFF, 16'hFFFF,
                                                   16'h0000};
   logic [ADDR_W-1:0] phase_high  [NUM_PHASES] = '{16'hFFFF, 16'h9000, 16'h1000, 16'h1000,
                                                   16'hC000, 16'h0000, 16'hFFFF, 16'h0000,
                                                   16'hFFFF};
   logic              phase_remap [NUM_PHASES] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1,
                                                   1'b0, 1'b1, 1'b1};

   always #1 clock = ~clock;

   banked_memory_word_access u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .req_bank_select  (req_bank_select),
      .rsp_valid        (rsp_valid),
      .rsp_read_data    (rsp_read_data),
      .rsp_fault        (rsp_fault),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   bmwa_access_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .req_bank_select  (req_bank_select),
      .rsp_valid        (rsp_valid),
      .rsp_read_data    (rsp_read_data),
      .rsp_fault        (rsp_fault),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .failures         (failures),
      .outstanding      (outstanding)
   );

   function automatic int byte_home(input logic [ADDR_W-1:0] addr,
                                    input logic [ADDR_W-1:0] bank_sel);
      if (int'(addr) < HALF_SIZE) return int'(addr);
      return HALF_SIZE * (1 + int'(bank_sel % ADDR_W'(NUM_BANKS))) + int'(addr) - HALF_SIZE;
   endfunction

   // Addresses cluster near the half split, the top and the range edges so reads hit
   function automatic logic [ADDR_W-1:0] pick_address();
      logic [ADDR_W-1:0] base;
      case ($urandom_range(7))
         0:       base = 16'h0000;
         1:       base = 16'h7FF8;
         2:       base = 16'h8000;
         3:       base = 16'hFFF8;
         4:       base = cur_low - 16'd4;
         5:       base = cur_high - 16'd4;
         6:       base = cur_high - cur_low - 16'd4;
         default: return ADDR_W'($urandom);
      endcase
      return base + ADDR_W'($urandom_range(7));
   endfunction

   // Sends one request. A read of a byte never written becomes a byte write of it.
   // Word writes only mark their first byte, since the second may be cut off by a fault.
   task automatic issue(input logic [1:0]        kind,
                        input logic [ADDR_W-1:0] addr,
                        input logic [DATA_W-1:0] data,
                        input logic [ADDR_W-1:0] bank_sel);
      int first_home;
      int second_home;
      bit took;
      first_home  = byte_home(addr, bank_sel);
      second_home = byte_home(ADDR_W'(addr + ADDR_W'(1)), bank_sel);
      if (kind == REQ_BYTE_READ && !byte_written[first_home]) begin
         kind = REQ_BYTE_WRITE;
      end else if (kind == REQ_WORD_READ) begin
         if (!byte_written[first_home]) begin
            kind = REQ_BYTE_WRITE;
         end else if (!byte_written[second_home]) begin
            kind       = REQ_BYTE_WRITE;
            addr       = addr + ADDR_W'(1);
            first_home = second_home;
         end
      end
      if (kind == REQ_BYTE_WRITE || kind == REQ_WORD_WRITE) byte_written[first_home] = 1'b1;
      while (idle_enable && $urandom_range(99) < 38) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_type        <= kind;
      req_address     <= addr;
      req_write_data  <= data;
      req_bank_select <= bank_sel;
      do begin
         @(negedge clock);
         took = !busy;
         @(posedge clock);
      end while (!took);
   endtask

   task automatic drain();
      do @(negedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_window(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi,
                             input logic remap);
      drain();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_RANGE_LOW;
      csr_write_data   <= lo;
      @(posedge clock);
      csr_index        <= CSR_RANGE_HIGH;
      csr_write_data   <= hi;
      @(posedge clock);
      csr_index        <= CSR_REMAP_ENABLE;
      csr_write_data   <= DATA_W'(remap);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_low  = lo;
      cur_high = hi;
   endtask

   task automatic directed_requests();
      issue(REQ_BYTE_WRITE, 16'h0000, 16'hAB5A, 16'h0000);  // high data byte ignored
      issue(REQ_BYTE_WRITE, 16'h0001, 16'hFFFF, 16'hFFFF);
      issue(REQ_WORD_READ,  16'h0000, 16'h0000, 16'h0000);
      issue(REQ_BYTE_READ,  16'h0001, 16'hFFFF, 16'h1234);
      // word straddling the half split lands in bank 3
      issue(REQ_BYTE_WRITE, 16'h8000, 16'h0099, 16'h0003);
      issue(REQ_WORD_WRITE, 16'h7FFF, 16'h1234, 16'hFFFF);
      issue(REQ_WORD_READ,  16'h7FFF, 16'h0000, 16'h0007);
      issue(REQ_BYTE_READ,  16'h8000, 16'h0000, 16'hFFFF);
      issue(REQ_BYTE_WRITE, 16'h8000, 16'h0011, 16'h0000);
      issue(REQ_BYTE_WRITE, 16'h8000, 16'h0022, 16'h0001);
      issue(REQ_BYTE_WRITE, 16'h8000, 16'h0033, 16'h0002);
      issue(REQ_BYTE_READ,  16'h8000, 16'h0000, 16'h0004);
      issue(REQ_BYTE_READ,  16'h8000, 16'h0000, 16'h0005);
      issue(REQ_BYTE_READ,  16'h8000, 16'h0000, 16'hFFFE);
      issue(REQ_BYTE_READ,  16'h8000, 16'h0000, 16'h0003);
      // word at the top address: first byte only, fault reported
      issue(REQ_WORD_WRITE, 16'hFFFF, 16'hBEEF, 16'h0000);
      issue(REQ_BYTE_READ,  16'hFFFF, 16'h0000, 16'h0004);
      issue(REQ_WORD_READ,  16'hFFFF, 16'h0000, 16'h0000);
      issue(REQ_BYTE_WRITE, 16'hFFFE, 16'h0000, 16'h0000);
      issue(REQ_WORD_READ,  16'hFFFE, 16'h0000, 16'h0008);
      issue(REQ_BYTE_WRITE, 16'h4001, 16'hFFFF, 16'h0000);
      issue(REQ_WORD_WRITE, 16'h4000, 16'h0000, 16'h0000);
      issue(REQ_WORD_READ,  16'h4000, 16'hFFFF, 16'hFFFF);
   endtask

   task automatic random_requests(input int count);
      logic [ADDR_W-1:0] bank_sel;
      for (int i = 0; i < count; i++) begin
         bank_sel = $urandom_range(1) ? ADDR_W'($urandom_range(7)) : ADDR_W'($urandom);
         issue(2'($urandom_range(3)), pick_address(), DATA_W'($urandom), bank_sel);
      end
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_requests();
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p != 0) begin
            start <= 1'b0;
            set_window(phase_low[p], phase_high[p], phase_remap[p]);
         end
         // back-to-back requests through the middle phases
         idle_enable = !(p == 4 || p == 5);
         random_requests(RANDOM_PER_PHASE);
      end
      start <= 1'b0;
      drain();
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== banked_memory_word_access.f =====
rtl/bmwa_pkg.sv
rtl/bmwa_byte_ram.sv
rtl/banked_memory_word_access.sv
bench/bmwa_access_checker.sv
bench/banked_memory_word_access_tb.sv
